// ===== sv/bom_pkg.sv =====
// Package for the billboard orientation matrix block.
// Fixed-point widths, Newton seeds, pipeline latencies, shared types.
// No dependencies.
`default_nettype none

package bom_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int NEWTON_STEPS = 5;

    // vector width seen by the normalizer: holds pos - cam and a cross of unit rows
    localparam int NW     = (2 * FRAC_BITS + 4 > 34) ? 2 * FRAC_BITS + 4 : 34;
    localparam int LW     = $clog2(NW + 1);
    localparam int UNIT_W = FRAC_BITS + 3;

    localparam logic [31:0] SEED_LOW  = 32'd912680550;
    localparam logic [31:0] SEED_HIGH = 32'd644245094;
    localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

    localparam int NEWTON_LAT = 3 * NEWTON_STEPS;
    localparam int NORM_LAT   = 4 + NEWTON_LAT + 2;
    localparam int CROSS_LAT  = 2;
    localparam int SCALE_LAT  = 2;
    localparam int TOTAL_LAT  = 1 + NORM_LAT + NORM_LAT + CROSS_LAT + NORM_LAT + SCALE_LAT;

    typedef struct packed {
        logic [29:0]       x;
        logic [31:0]       y;
        logic [33:0]       y2;
        logic [35:0]       p;
        logic [2:0]        k;
        logic [2:0][29:0]  mm;
        logic [2:0]        sgn;
        logic              zero;
    } t_nrm;

    typedef enum logic [1:0] {
        REG_POS_X = 2'd0,
        REG_POS_Y = 2'd1,
        REG_POS_Z = 2'd2,
        REG_SCALE = 2'd3
    } t_reg;

endpackage

`default_nettype wire

// ===== sv/billboard_orientation_matrix_core.sv =====
// Pipeline: 3 normalizers of 21 stages, cross, scale, from input accept to o_valid.
// Throughput: one word per cycle while o_stall is low; each normalizer is fully pipelined.
// Output register plus one skid word; o_stall rises only when both hold a word.
// Reset (synchronous, active low) clears valids and loads pos = 0, scale = 1.0.
// Top level: APB register file, vector pipeline; uses bom_pkg and bom_norm.
`default_nettype none

module billboard_orientation_matrix_core import bom_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_cam_x,
    input  wire logic [31:0] i_cam_y,
    input  wire logic [31:0] i_cam_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [31:0] o_right_sx,
    output logic      [31:0] o_right_sy,
    output logic      [31:0] o_right_sz,
    output logic      [31:0] o_up_sx,
    output logic      [31:0] o_up_sy,
    output logic      [31:0] o_up_sz,
    output logic      [31:0] o_fwd_sx,
    output logic      [31:0] o_fwd_sy,
    output logic      [31:0] o_fwd_sz,
    output logic             o_degenerate
);

    typedef struct packed {
        logic [8:0][31:0] v;
        logic             deg;
    } t_word;

    // registers
    logic [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic [23:0] r_scale;
    t_reg        w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_scale <= 24'(1 << FRAC_BITS);
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_POS_X: r_pos_x <= pwdata;
                REG_POS_Y: r_pos_y <= pwdata;
                REG_POS_Z: r_pos_z <= pwdata;
                REG_SCALE: r_scale <= pwdata[23:0];
                default:   r_scale <= r_scale;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_POS_X: prdata = r_pos_x;
            REG_POS_Y: prdata = r_pos_y;
            REG_POS_Z: prdata = r_pos_z;
            REG_SCALE: prdata = {8'd0, r_scale};
            default:   prdata = '0;
        endcase
    end

    // flow control
    logic                 w_en;
    logic                 r_skid_v;
    logic                 r_out_v;
    logic [TOTAL_LAT-1:0] r_vp;

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else if (w_en) begin
            r_vp <= {r_vp[TOTAL_LAT-2:0], i_valid};
        end
    end

    // pos - cam
    logic [2:0][NW-1:0] r_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= NW'($signed(r_pos_x)) - NW'($signed(i_cam_x));
            r_d[1] <= NW'($signed(r_pos_y)) - NW'($signed(i_cam_y));
            r_d[2] <= NW'($signed(r_pos_z)) - NW'($signed(i_cam_z));
        end
    end

    // forward
    logic [2:0][UNIT_W-1:0] w_f;
    logic                   w_fok;

    bom_norm u_norm_fwd (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_d),
        .o_unit (w_f),
        .o_ok   (w_fok)
    );

    // right = normalize(f.z, 0, -f.x)
    logic [2:0][NW-1:0]     w_rr;
    logic [2:0][UNIT_W-1:0] w_r;
    logic                   w_rok;

    assign w_rr[0] = NW'($signed(w_f[2]));
    assign w_rr[1] = '0;
    assign w_rr[2] = NW'($signed(UNIT_W'(0) - w_f[0]));

    bom_norm u_norm_right (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (w_rr),
        .o_unit (w_r),
        .o_ok   (w_rok)
    );

    logic [2:0][UNIT_W-1:0] r_fd1 [NORM_LAT];
    logic                   r_okd1 [NORM_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fd1[0]  <= w_f;
            r_okd1[0] <= w_fok;
            for (int i = 1; i < NORM_LAT; i++) begin
                r_fd1[i]  <= r_fd1[i-1];
                r_okd1[i] <= r_okd1[i-1];
            end
        end
    end

    // up = cross(f, r)
    logic [5:0][2*UNIT_W-1:0] r_cp;
    logic [2:0][UNIT_W-1:0]   r_cf1, r_cr1, r_cf2, r_cr2;
    logic                     r_cdeg1, r_cdeg2;
    logic [2:0][NW-1:0]       r_ur;
    logic [2:0][UNIT_W-1:0]   w_fa, w_ra;

    assign w_fa = r_fd1[NORM_LAT-1];
    assign w_ra = w_r;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cp[0] <= (2*UNIT_W)'($signed(w_fa[1]) * $signed(w_ra[2]));
            r_cp[1] <= (2*UNIT_W)'($signed(w_fa[2]) * $signed(w_ra[1]));
            r_cp[2] <= (2*UNIT_W)'($signed(w_fa[2]) * $signed(w_ra[0]));
            r_cp[3] <= (2*UNIT_W)'($signed(w_fa[0]) * $signed(w_ra[2]));
            r_cp[4] <= (2*UNIT_W)'($signed(w_fa[0]) * $signed(w_ra[1]));
            r_cp[5] <= (2*UNIT_W)'($signed(w_fa[1]) * $signed(w_ra[0]));
            r_cf1   <= w_fa;
            r_cr1   <= w_ra;
            r_cdeg1 <= !(r_okd1[NORM_LAT-1] && w_rok);
            r_ur[0] <= NW'($signed(r_cp[0])) - NW'($signed(r_cp[1]));
            r_ur[1] <= NW'($signed(r_cp[2])) - NW'($signed(r_cp[3]));
            r_ur[2] <= NW'($signed(r_cp[4])) - NW'($signed(r_cp[5]));
            r_cf2   <= r_cf1;
            r_cr2   <= r_cr1;
            r_cdeg2 <= r_cdeg1;
        end
    end

    logic [2:0][UNIT_W-1:0] w_u;

    bom_norm u_norm_up (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_ur),
        .o_unit (w_u),
        .o_ok   ()
    );

    logic [2:0][UNIT_W-1:0] r_fd2 [NORM_LAT];
    logic [2:0][UNIT_W-1:0] r_rd2 [NORM_LAT];
    logic                   r_degd2 [NORM_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fd2[0]   <= r_cf2;
            r_rd2[0]   <= r_cr2;
            r_degd2[0] <= r_cdeg2;
            for (int i = 1; i < NORM_LAT; i++) begin
                r_fd2[i]   <= r_fd2[i-1];
                r_rd2[i]   <= r_rd2[i-1];
                r_degd2[i] <= r_degd2[i-1];
            end
        end
    end

    // scale and saturate
    localparam int PW = UNIT_W + 24;

    logic [8:0][UNIT_W-1:0] w_all;
    logic [8:0][PW-1:0]     r_sp;
    logic [8:0]             r_ssgn;
    logic                   r_sdeg;
    logic [UNIT_W-1:0]      w_mag [9];
    t_word                  n_tail, r_tail;
    logic [PW-1:0]          w_rs;

    assign w_all = {r_fd2[NORM_LAT-1], w_u, r_rd2[NORM_LAT-1]};

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_mag[i] = w_all[i][UNIT_W-1] ? (UNIT_W'(0) - w_all[i]) : w_all[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 9; i++) begin
                r_sp[i]   <= PW'(w_mag[i]) * PW'(r_scale);
                r_ssgn[i] <= w_all[i][UNIT_W-1];
            end
            r_sdeg <= r_degd2[NORM_LAT-1];
        end
    end

    always_comb begin
        n_tail.deg = r_sdeg;
        for (int i = 0; i < 9; i++) begin
            w_rs = (r_sp[i] + PW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (r_ssgn[i]) begin
                n_tail.v[i] = (w_rs > PW'(33'h8000_0000)) ? 32'h8000_0000
                                                          : 32'd0 - w_rs[31:0];
            end else begin
                n_tail.v[i] = (w_rs > PW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : w_rs[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_tail <= n_tail;
    end

    // output register and skid word
    logic  w_out_free;
    t_word r_out, r_skid;

    assign w_out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_vp[TOTAL_LAT-1];
            end
        end else if (r_vp[TOTAL_LAT-1] && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_v ? r_skid : r_tail;
        end else if (w_en) begin
            r_skid <= r_tail;
        end
    end

    assign o_valid      = r_out_v;
    assign o_right_sx   = r_out.v[0];
    assign o_right_sy   = r_out.v[1];
    assign o_right_sz   = r_out.v[2];
    assign o_up_sx      = r_out.v[3];
    assign o_up_sy      = r_out.v[4];
    assign o_up_sz      = r_out.v[5];
    assign o_fwd_sx     = r_out.v[6];
    assign o_fwd_sy     = r_out.v[7];
    assign o_fwd_sz     = r_out.v[8];
    assign o_degenerate = r_out.deg;

endmodule

`default_nettype wire

// ===== sv/bom_norm.sv =====
// Pipelined 3-vector normalizer: magnitude align, sum of squares,
// Newton reciprocal square root, rounded unit rows. Uses bom_pkg.
`default_nettype none

module bom_norm import bom_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [2:0][NW-1:0]       i_vec,
    output logic      [2:0][UNIT_W-1:0]   o_unit,
    output logic                          o_ok
);

    function automatic logic [LW-1:0] bit_len(input logic [NW-1:0] a);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < NW; i++) begin
            if (a[i]) n = LW'(i + 1);
        end
        return n;
    endfunction

    // stage 1: sign/magnitude, max
    logic [2:0][NW-1:0] n1_m;
    logic [2:0]         n1_sgn;
    logic [NW-1:0]      n1_a;
    logic [2:0][NW-1:0] r1_m;
    logic [2:0]         r1_sgn;
    logic [NW-1:0]      r1_a;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_sgn[i] = i_vec[i][NW-1];
            n1_m[i]   = n1_sgn[i] ? (NW'(0) - i_vec[i]) : i_vec[i];
        end
        n1_a = n1_m[0];
        if (n1_m[1] > n1_a) n1_a = n1_m[1];
        if (n1_m[2] > n1_a) n1_a = n1_m[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m   <= n1_m;
            r1_sgn <= n1_sgn;
            r1_a   <= n1_a;
        end
    end

    // stage 2: align so the largest has bit length 30
    logic [2:0][29:0] n2_mm;
    logic [NW-1:0]    n2_sh;
    int               n2_len;
    logic [2:0][29:0] r2_mm;
    logic [2:0]       r2_sgn;
    logic             r2_zero;

    always_comb begin
        n2_len = int'(bit_len(r1_a));
        for (int i = 0; i < 3; i++) begin
            if (n2_len > 30) n2_sh = r1_m[i] >> (n2_len - 30);
            else             n2_sh = r1_m[i] << (30 - n2_len);
            n2_mm[i] = n2_sh[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mm   <= n2_mm;
            r2_sgn  <= r1_sgn;
            r2_zero <= (r1_a == '0);
        end
    end

    // stage 3: squares
    logic [2:0][59:0] r3_sq;
    logic [2:0][29:0] r3_mm;
    logic [2:0]       r3_sgn;
    logic             r3_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= 60'(r2_mm[i]) * 60'(r2_mm[i]);
            end
            r3_mm   <= r2_mm;
            r3_sgn  <= r2_sgn;
            r3_zero <= r2_zero;
        end
    end

    // stage 4: sum, even shift into [2^60, 2^62), seed
    logic [63:0] n4_s;
    logic [2:0]  n4_k;
    t_nrm        n4_nt;
    t_nrm        r_nt [NEWTON_LAT+1];
    t_nrm        n_nt [NEWTON_LAT];

    always_comb begin
        n4_s = 64'(r3_sq[0]) + 64'(r3_sq[1]) + 64'(r3_sq[2]);
        n4_k = '0;
        for (int i = 0; i < 4; i++) begin
            if (n4_s < 64'h1000_0000_0000_0000) begin
                n4_s = n4_s << 2;
                n4_k = n4_k + 3'd1;
            end
        end
        n4_nt      = '0;
        n4_nt.x    = n4_s[61:32];
        n4_nt.y    = (n4_s[61:32] < 30'h2000_0000) ? SEED_LOW : SEED_HIGH;
        n4_nt.k    = n4_k;
        n4_nt.mm   = r3_mm;
        n4_nt.sgn  = r3_sgn;
        n4_nt.zero = r3_zero;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_nt[0] <= n4_nt;
    end

    // Newton steps, three registers each
    for (genvar j = 0; j < NEWTON_LAT; j++) begin : g_nt
        logic [63:0] w_prod;
        if (j % 3 == 0) begin : g_ysq
            assign w_prod = 64'(r_nt[j].y) * 64'(r_nt[j].y);
            always_comb begin
                n_nt[j]    = r_nt[j];
                n_nt[j].y2 = w_prod[63:30];
            end
        end else if (j % 3 == 1) begin : g_xy2
            assign w_prod = 64'(r_nt[j].x) * 64'(r_nt[j].y2);
            always_comb begin
                n_nt[j]   = r_nt[j];
                n_nt[j].p = w_prod[63:28];
            end
        end else begin : g_upd
            logic [31:0] w_fac;
            assign w_fac  = (r_nt[j].p >= 36'(THREE_Q30)) ? '0 : THREE_Q30 - r_nt[j].p[31:0];
            assign w_prod = 64'(r_nt[j].y) * 64'(w_fac);
            always_comb begin
                n_nt[j]   = r_nt[j];
                n_nt[j].y = w_prod[62:31];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_nt[j+1] <= n_nt[j];
        end
    end

    // final 1: m * y
    logic [2:0][61:0] rf_prod;
    logic [2:0]       rf_k;
    logic [2:0]       rf_sgn;
    logic             rf_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                rf_prod[i] <= 62'(r_nt[NEWTON_LAT].mm[i]) * 62'(r_nt[NEWTON_LAT].y);
            end
            rf_k    <= r_nt[NEWTON_LAT].k;
            rf_sgn  <= r_nt[NEWTON_LAT].sgn;
            rf_zero <= r_nt[NEWTON_LAT].zero;
        end
    end

    // final 2: round, shift, sign
    logic [2:0][UNIT_W-1:0] n_unit;
    logic [63:0]            nf_w;
    logic [UNIT_W-1:0]      nf_mag;
    int                     nf_sh;

    always_comb begin
        nf_sh = 60 - int'(rf_k) - FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            nf_w   = (64'(rf_prod[i]) + (64'd1 << (nf_sh - 1))) >> nf_sh;
            nf_mag = {1'b0, nf_w[UNIT_W-2:0]};
            if (rf_zero)        n_unit[i] = '0;
            else if (rf_sgn[i]) n_unit[i] = UNIT_W'(0) - nf_mag;
            else                n_unit[i] = nf_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_unit <= n_unit;
            o_ok   <= !rf_zero;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bom_checker.sv =====
// Port-level checks for billboard_orientation_matrix_core, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module bom_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_right_sx,
    input wire logic [31:0] o_right_sy,
    input wire logic [31:0] o_right_sz,
    input wire logic [31:0] o_up_sx,
    input wire logic [31:0] o_up_sy,
    input wire logic [31:0] o_up_sz,
    input wire logic [31:0] o_fwd_sx,
    input wire logic        o_degenerate
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_fwd_sx) && $stable(o_degenerate))
        else $error("stalled output word changed");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_right_sx == 0 && o_right_sz == 0 &&
                                    o_up_sx == 0 && o_up_sy == 0 && o_up_sz == 0)
        else $error("degenerate word with nonzero right or up row");

    a_right_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_right_sy == 0)
        else $error("right row has a y component");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> $past(o_valid && i_stall))
        else $error("input stalled without a blocked output");

endmodule

bind billboard_orientation_matrix_core bom_checker u_bom_checker (.*);

`default_nettype wire

// ===== dv/billboard_orientation_matrix_core_tb.sv =====
// Testbench for billboard_orientation_matrix_core: APB register setup, camera words in,
// rotation-scale rows checked against an in-bench fixed-point predictor.
// Depends on bom_pkg and the core RTL.
`timescale 1ns / 100ps

module billboard_orientation_matrix_core_tb;
    import bom_pkg::*;

    typedef struct packed {
        logic [31:0] cx, cy, cz;
    } t_cam;

    typedef struct packed {
        logic [31:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
        logic        degen;
    } t_rows;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_cam_x = '0, i_cam_y = '0, i_cam_z = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_right_sx, o_right_sy, o_right_sz, o_up_sx, o_up_sy, o_up_sz;
    logic [31:0] o_fwd_sx, o_fwd_sy, o_fwd_sz;
    logic        o_degenerate;

    billboard_orientation_matrix_core uut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    logic signed [63:0] obj_x = 0, obj_y = 0, obj_z = 0;
    logic [63:0]        obj_scale = 64'd1 << FRAC_BITS;

    t_cam  cam_q[$];
    t_rows rows_q[$];
    int    errors = 0;
    int    cycles = 0;
    int    idle_pct = 13;
    bit    hold_rx = 0;
    bit    sender_pause = 0;
    int    hold_cnt = 0;

    function automatic logic [63:0] magnitude(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit unit_vec(input logic signed [63:0] v[3],
                                    output logic signed [63:0] u[3]);
        logic [63:0] m[3];
        logic [63:0] a, s, x, y, y2, p, three, r;
        int len, k, sh;
        a = 0; s = 0; len = 0; k = 0;
        three = 64'd3 << 30;
        for (int i = 0; i < 3; i++) begin
            m[i] = magnitude(v[i]);
            if (m[i] > a) a = m[i];
        end
        if (a == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return 0;
        end
        while (len < 64 && (a >> len) != 0) len++;
        for (int i = 0; i < 3; i++) begin
            if (len > 30) m[i] = m[i] >> (len - 30);
            else m[i] = m[i] << (30 - len);
            s += m[i] * m[i];
        end
        while (s < (64'd1 << 60) && k < 4) begin
            s = s << 2;
            k++;
        end
        x = s >> 32;
        y = (x < (64'd1 << 29)) ? 64'(SEED_LOW) : 64'(SEED_HIGH);
        for (int i = 0; i < NEWTON_STEPS; i++) begin
            y2 = (y * y) >> 30;
            p = (x * y2) >> 28;
            y = (p >= three) ? 64'd0 : ((y * (three - p)) >> 31);
        end
        sh = 60 - k - FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            r = (m[i] * y + (64'd1 << (sh - 1))) >> sh;
            u[i] = v[i] < 0 ? -$signed(r) : $signed(r);
        end
        return 1;
    endfunction

    function automatic logic [31:0] scaled(logic signed [63:0] u);
        logic [63:0] r;
        r = (magnitude(u) * obj_scale + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (u < 0) return (r > 64'h8000_0000) ? 32'h8000_0000 : 32'(-$signed(r));
        return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    endfunction

    function automatic t_rows billboard_rows(t_cam c);
        logic signed [63:0] d[3], f[3], rr[3], r[3], ur[3], up[3];
        bit fok, rok;
        t_rows o;
        d[0] = obj_x - $signed(c.cx);
        d[1] = obj_y - $signed(c.cy);
        d[2] = obj_z - $signed(c.cz);
        fok = unit_vec(d, f);
        rr[0] = f[2]; rr[1] = 0; rr[2] = -f[0];
        rok = unit_vec(rr, r);
        ur[0] = f[1] * r[2] - f[2] * r[1];
        ur[1] = f[2] * r[0] - f[0] * r[2];
        ur[2] = f[0] * r[1] - f[1] * r[0];
        void'(unit_vec(ur, up));
        o.rx = scaled(r[0]); o.ry = scaled(r[1]); o.rz = scaled(r[2]);
        o.ux = scaled(up[0]); o.uy = scaled(up[1]); o.uz = scaled(up[2]);
        o.fx = scaled(f[0]); o.fy = scaled(f[1]); o.fz = scaled(f[2]);
        o.degen = !(fok && rok);
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) rows_q.push_back(billboard_rows({i_cam_x, i_cam_y, i_cam_z}));
            if (cam_q.size() > 0 && !sender_pause && $urandom_range(99) >= idle_pct) begin
                t_cam c;
                c = cam_q.pop_front();
                i_cam_x <= c.cx; i_cam_y <= c.cy; i_cam_z <= c.cz;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_rows e;
            if (rows_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = rows_q.pop_front();
                if (o_right_sx !== e.rx) begin
                    $error("right_sx exp %h got %h", e.rx, o_right_sx); errors++; end
                if (o_right_sy !== e.ry) begin
                    $error("right_sy exp %h got %h", e.ry, o_right_sy); errors++; end
                if (o_right_sz !== e.rz) begin
                    $error("right_sz exp %h got %h", e.rz, o_right_sz); errors++; end
                if (o_up_sx !== e.ux) begin
                    $error("up_sx exp %h got %h", e.ux, o_up_sx); errors++; end
                if (o_up_sy !== e.uy) begin
                    $error("up_sy exp %h got %h", e.uy, o_up_sy); errors++; end
                if (o_up_sz !== e.uz) begin
                    $error("up_sz exp %h got %h", e.uz, o_up_sz); errors++; end
                if (o_fwd_sx !== e.fx) begin
                    $error("fwd_sx exp %h got %h", e.fx, o_fwd_sx); errors++; end
                if (o_fwd_sy !== e.fy) begin
                    $error("fwd_sy exp %h got %h", e.fy, o_fwd_sy); errors++; end
                if (o_fwd_sz !== e.fz) begin
                    $error("fwd_sz exp %h got %h", e.fz, o_fwd_sz); errors++; end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate exp %b got %b", e.degen, o_degenerate); errors++; end
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_rx && hold_cnt < 300) begin
            hold_cnt <= hold_cnt + 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic apb_write(t_reg idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_POS_X: obj_x = $signed(val);
            REG_POS_Y: obj_y = $signed(val);
            REG_POS_Z: obj_z = $signed(val);
            default:   obj_scale = {40'd0, val[23:0]};
        endcase
    endtask

    task automatic drain();
        while (cam_q.size() > 0 || i_valid || rows_q.size() > 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 10) @(posedge i_clk);
    endtask

    task automatic add_cam(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        cam_q.push_back({x, y, z});
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic random_phase(int n);
        int mode;
        logic [31:0] x, y, z;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(3);
            x = rnd_coord(mode);
            y = rnd_coord($urandom_range(2));
            z = rnd_coord(mode);
            case ($urandom_range(15))
                0: begin x = obj_x[31:0]; y = obj_y[31:0]; z = obj_z[31:0]; end
                1: begin x = obj_x[31:0]; z = obj_z[31:0]; end
                2: x = obj_x[31:0];
                default: ;
            endcase
            add_cam(x, y, z);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed, reset config
        add_cam(0, 0, 0);
        add_cam(0, 32'h0001_0000, 0);
        add_cam(0, 32'hFFFF_0000, 0);
        add_cam(32'h0001_0000, 0, 0);
        add_cam(0, 0, 32'h0001_0000);
        add_cam(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_cam(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_cam(32'h8000_0000, 0, 32'h7FFF_FFFF);
        add_cam(1, 0, 0);
        add_cam(1, 1, 1);
        add_cam(32'hFFFF_FFFF, 32'h1234_5678, 0);
        drain();
        apb_write(REG_POS_X, 32'h7FFF_FFFF);
        apb_write(REG_POS_Y, 32'h8000_0000);
        apb_write(REG_POS_Z, 32'h7FFF_FFFF);
        apb_write(REG_SCALE, 24'hFF_FFFF);
        add_cam(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_cam(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
        add_cam(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_cam(0, 0, 0);
        add_cam(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
        drain();
        apb_write(REG_SCALE, 0);
        add_cam(0, 0, 0);
        add_cam(32'h0001_0000, 0, 0);
        drain();
        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            apb_write(REG_POS_X, ph == 0 ? 32'h8000_0000 : $urandom);
            apb_write(REG_POS_Y, rnd_coord($urandom_range(3)));
            apb_write(REG_POS_Z, ph == 1 ? 32'h7FFF_FFFF : rnd_coord(1));
            apb_write(REG_SCALE, ph == 2 ? 24'hFF_FFFF : $urandom_range(24'hFF_FFFF));
            idle_pct = (ph == 3) ? 0 : 13;
            if (ph == 4) begin
                hold_rx = 1;
                random_phase(120);
                while (hold_cnt < 300) @(posedge i_clk);
                hold_rx = 0;
                sender_pause = 1;
                while (i_valid || rows_q.size() > 0) @(posedge i_clk);
                sender_pause = 0;
            end
            random_phase(220);
            drain();
        end
        idle_pct = 13;
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
